// File: design/irrigation_pump_guard_defines.svh
// Assertion macros for the irrigation pump guard.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef IRRIGATION_PUMP_GUARD_DEFINES_SVH
`define IRRIGATION_PUMP_GUARD_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ipg_pkg.sv
// Package for the irrigation pump guard: command and register codes,
// register reset values and fixed limits. No dependencies.
`default_nettype none

package ipg_pkg;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } pump_cmd_e;

  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_HYSTERESIS = 3'd1,
    REG_START_HOUR = 3'd2,
    REG_END_HOUR   = 3'd3,
    REG_SP_OFFSET  = 3'd4,
    REG_DAILY_LIM  = 3'd5,
    REG_RUN_LIM    = 3'd6,
    REG_HOLD_MS    = 3'd7
  } cfg_reg_e;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // 24 hour window span in ms
  localparam logic [31:0] WindowSpanMs = 32'd86_400_000;

  // setpoint clamp, tenths of a percent
  localparam logic signed [12:0] SetpMinTenths = 13'sd300;
  localparam logic signed [12:0] SetpMaxTenths = 13'sd900;

  localparam logic [6:0]  RstSetpoint   = 7'd65;
  localparam logic [5:0]  RstHysteresis = 6'd5;
  localparam logic [4:0]  RstStartHour  = 5'd7;
  localparam logic [4:0]  RstEndHour    = 5'd20;
  localparam logic [10:0] RstSpOffset   = 11'd0;
  localparam logic [26:0] RstDailyLim   = 27'd1_200_000;
  localparam logic [26:0] RstRunLim     = 27'd300_000;
  localparam logic [26:0] RstHoldMs     = 27'd300_000;

endpackage

`default_nettype wire

// File: design/irrigation_pump_guard.sv
// Irrigation pump guard top level: config registers, input stage, guard and
// hysteresis logic, result register. Uses ipg_pkg and the assertion header.
`default_nettype none

// irrigation_pump_guard
// Takes one beat per cycle unless in_stall_o is high: a control step or a
// manual pump request, with a millisecond timestamp, the actual pump state,
// a soil moisture reading and the hour of day. For every beat it returns
// one result beat with the pump command (none/on/off), the lockout flag,
// the runtime accumulated in the current 24 hour window and the manual
// hold flag. An accepted beat is registered in the input register and then
// moves on to the result register when that is empty or being drained.
// Throughput is one beat per cycle while the consumer does not stall. The
// guard state is updated in the same cycle that produces the result, so
// back-to-back beats see each other's effects. The input side stalls only
// while both the input and the result register hold beats and the result
// consumer stalls. Configuration goes through the APB port (byte address
// 4*index, always ready) and must be written while no beat is in flight.
module irrigation_pump_guard
  import ipg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  // config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output      logic [DataW-1:0]  prdata,
  output      logic              pready,

  // input channel
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic              pump_running_i,
  input  wire logic              moisture_valid_i,
  input  wire logic [9:0]        soil_moisture_i,
  input  wire logic [4:0]        hour_of_day_i,

  // result channel
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [1:0]        pump_command_o,
  output      logic              pump_locked_o,
  output      logic [31:0]       window_runtime_ms_o,
  output      logic              manual_hold_active_o
);

`include "irrigation_pump_guard_defines.svh"

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [6:0]  setpoint_q;
  logic [5:0]  hysteresis_q;
  logic [4:0]  start_hour_q;
  logic [4:0]  end_hour_q;
  logic [10:0] sp_offset_q;
  logic [26:0] daily_lim_q;
  logic [26:0] run_lim_q;
  logic [26:0] hold_ms_q;

  logic     cfg_wr;
  cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= RstSetpoint;
      hysteresis_q <= RstHysteresis;
      start_hour_q <= RstStartHour;
      end_hour_q   <= RstEndHour;
      sp_offset_q  <= RstSpOffset;
      daily_lim_q  <= RstDailyLim;
      run_lim_q    <= RstRunLim;
      hold_ms_q    <= RstHoldMs;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_SETPOINT:   setpoint_q   <= pwdata[6:0];
        REG_HYSTERESIS: hysteresis_q <= pwdata[5:0];
        REG_START_HOUR: start_hour_q <= pwdata[4:0];
        REG_END_HOUR:   end_hour_q   <= pwdata[4:0];
        REG_SP_OFFSET:  sp_offset_q  <= pwdata[10:0];
        REG_DAILY_LIM:  daily_lim_q  <= pwdata[26:0];
        REG_RUN_LIM:    run_lim_q    <= pwdata[26:0];
        REG_HOLD_MS:    hold_ms_q    <= pwdata[26:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register bits, zero extended.
  always_comb begin
    case (cfg_sel)
      REG_SETPOINT:   prdata = {25'd0, setpoint_q};
      REG_HYSTERESIS: prdata = {26'd0, hysteresis_q};
      REG_START_HOUR: prdata = {27'd0, start_hour_q};
      REG_END_HOUR:   prdata = {27'd0, end_hour_q};
      REG_SP_OFFSET:  prdata = {21'd0, sp_offset_q};
      REG_DAILY_LIM:  prdata = {5'd0, daily_lim_q};
      REG_RUN_LIM:    prdata = {5'd0, run_lim_q};
      REG_HOLD_MS:    prdata = {5'd0, hold_ms_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Flow control: the result register advances whenever it is empty or
  // being drained this cycle; the input register loads whenever it is
  // empty or its beat moves on.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic advance;
  logic in_take;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input payload register; hold while stalled.
  logic        s1_req_q;
  logic [31:0] s1_now_q;
  logic        s1_pump_q;
  logic        s1_mvalid_q;
  logic [9:0]  s1_sm_q;
  logic [4:0]  s1_hour_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q    <= req_type_i;
      s1_now_q    <= now_ms_i;
      s1_pump_q   <= pump_running_i;
      s1_mvalid_q <= moisture_valid_i;
      s1_sm_q     <= soil_moisture_i;
      s1_hour_q   <= hour_of_day_i;
    end
  end

  logic s1_fire;
  assign s1_fire = s1_valid_q && advance;

  // ---------------------------------------------------------------------
  // Guard state
  // ---------------------------------------------------------------------
  logic [31:0] win_start_q, win_start_d;
  logic [31:0] last_upd_q,  last_upd_d;
  logic        last_pump_q, last_pump_d;
  logic [31:0] run_start_q, run_start_d;
  logic        lock_q,      lock_d;
  logic [31:0] accum_q,     accum_d;
  logic [31:0] man_until_q, man_until_d;

  // Window start: a zero start means not started, so seed everything.
  logic        win_fresh;
  logic [31:0] ws1, lu1, rs1;
  logic        lps1;
  logic [31:0] win_age;
  logic        win_expired;
  logic [31:0] ws2, acc2;
  logic        lock2;
  logic [31:0] dt;
  logic [32:0] acc_sum;
  logic [31:0] acc3;
  logic [31:0] rs3;
  logic [31:0] run_age;
  logic        over_daily, over_run;
  logic        lock3;

  always_comb begin
    win_fresh = (win_start_q == '0);
    ws1  = win_fresh ? s1_now_q  : win_start_q;
    lu1  = win_fresh ? s1_now_q  : last_upd_q;
    lps1 = win_fresh ? s1_pump_q : last_pump_q;
    rs1  = win_fresh ? (s1_pump_q ? s1_now_q : '0) : run_start_q;

    // Restart the window once it is older than a day.
    win_age     = s1_now_q - ws1;
    win_expired = win_age > WindowSpanMs;
    ws2   = win_expired ? s1_now_q : ws1;
    acc2  = win_expired ? '0 : accum_q;
    lock2 = win_expired ? 1'b0 : lock_q;

    // Add elapsed time while the pump was on; saturate on carry.
    dt      = s1_now_q - lu1;
    acc_sum = {1'b0, acc2} + {1'b0, dt};
    if (lps1) begin
      acc3 = acc_sum[32] ? '1 : acc_sum[31:0];
    end else begin
      acc3 = acc2;
    end

    rs3 = (s1_pump_q && !lps1) ? s1_now_q : rs1;

    run_age    = s1_now_q - rs3;
    over_daily = acc3 > {5'd0, daily_lim_q};
    over_run   = s1_pump_q && (rs3 != '0) && (run_age > {5'd0, run_lim_q});
    lock3      = lock2 || over_daily || over_run;
  end

  // ---------------------------------------------------------------------
  // Hysteresis around the clamped setpoint (tenths of a percent)
  // ---------------------------------------------------------------------
  logic signed [12:0] sp_raw, sp_clamped, hy, band_lo, band_hi, sm_s;
  logic               in_hours;

  always_comb begin
    sp_raw = $signed({2'b00, {4'd0, setpoint_q} * 11'd10})
           + $signed({{2{sp_offset_q[10]}}, sp_offset_q});
    if (sp_raw < SetpMinTenths) begin
      sp_clamped = SetpMinTenths;
    end else if (sp_raw > SetpMaxTenths) begin
      sp_clamped = SetpMaxTenths;
    end else begin
      sp_clamped = sp_raw;
    end
    hy      = $signed({3'b000, {4'd0, hysteresis_q} * 10'd10});
    band_lo = sp_clamped - hy;
    band_hi = sp_clamped + hy;
    sm_s    = $signed({3'b000, s1_sm_q});

    // Hour window; a start past the end wraps over midnight.
    if (start_hour_q == end_hour_q) begin
      in_hours = 1'b1;
    end else if (start_hour_q < end_hour_q) begin
      in_hours = (s1_hour_q >= start_hour_q) && (s1_hour_q < end_hour_q);
    end else begin
      in_hours = (s1_hour_q >= start_hour_q) || (s1_hour_q < end_hour_q);
    end
  end

  // ---------------------------------------------------------------------
  // Next state and result
  // ---------------------------------------------------------------------
  pump_cmd_e   cmd;
  logic        res_lock;
  logic [31:0] res_accum;
  logic        res_hold;
  logic        hold_now;

  // Plain unsigned compare against the hold end; a zero end is no hold.
  assign hold_now = (man_until_q != '0) && (s1_now_q < man_until_q);

  always_comb begin
    win_start_d = win_start_q;
    last_upd_d  = last_upd_q;
    last_pump_d = last_pump_q;
    run_start_d = run_start_q;
    lock_d      = lock_q;
    accum_d     = accum_q;
    man_until_d = man_until_q;
    cmd         = CMD_NONE;
    res_lock    = lock_q;
    res_accum   = accum_q;
    res_hold    = hold_now;

    if (s1_req_q) begin
      // Manual request: start the hold, leave the guard alone.
      man_until_d = s1_now_q + {5'd0, hold_ms_q};
      res_hold    = (man_until_d != '0) && (s1_now_q < man_until_d);
    end else begin
      win_start_d = ws2;
      last_upd_d  = s1_now_q;
      last_pump_d = s1_pump_q;
      run_start_d = rs3;
      lock_d      = lock3;
      accum_d     = acc3;
      res_lock    = lock3;
      res_accum   = acc3;

      if (lock3) begin
        cmd = s1_pump_q ? CMD_OFF : CMD_NONE;
      end else if (hold_now) begin
        cmd = CMD_NONE;
      end else if (!in_hours || !s1_mvalid_q) begin
        cmd = s1_pump_q ? CMD_OFF : CMD_NONE;
      end else if (!s1_pump_q && (sm_s < band_lo)) begin
        cmd = CMD_ON;
      end else if (s1_pump_q && (sm_s > band_hi)) begin
        cmd = CMD_OFF;
      end else begin
        cmd = CMD_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      last_upd_q  <= '0;
      last_pump_q <= 1'b0;
      run_start_q <= '0;
      lock_q      <= 1'b0;
      accum_q     <= '0;
      man_until_q <= '0;
    end else if (s1_fire) begin
      win_start_q <= win_start_d;
      last_upd_q  <= last_upd_d;
      last_pump_q <= last_pump_d;
      run_start_q <= run_start_d;
      lock_q      <= lock_d;
      accum_q     <= accum_d;
      man_until_q <= man_until_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: load on advance, hold while the consumer stalls.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pump_command_o       <= cmd;
      pump_locked_o        <= res_lock;
      window_runtime_ms_o  <= res_accum;
      manual_hold_active_o <= res_hold;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `IPG_ASSERT_NOW(a_lock_never_on, out_valid_o && pump_locked_o, pump_command_o != CMD_ON, "pump switched on while locked")
  `IPG_ASSERT_NOW(a_hold_quiet, out_valid_o && manual_hold_active_o && !pump_locked_o, pump_command_o == CMD_NONE, "command issued during manual hold")
  `IPG_ASSERT_NOW(a_stall_cause, in_stall_o, s1_valid_q && out_valid_o && out_stall_i, "input stalled without a full pipe")
  `IPG_ASSERT_NEXT(a_s1_kept, s1_valid_q && out_valid_o && out_stall_i, s1_valid_q, "input stage dropped a beat under stall")

endmodule

`default_nettype wire

// File: verif/tb.sv
// Testbench for irrigation_pump_guard: drives control steps and manual requests
// through the input channel and checks every result beat against a predictor.
// Depends on ipg_pkg and the irrigation_pump_guard RTL only.
`timescale 1ns / 1ps

module tb;
  import ipg_pkg::*;

  // One input beat and one result beat, at the block's widths.
  typedef struct packed {
    logic        req;
    logic [31:0] now;
    logic        pump;
    logic        valid;
    logic [9:0]  sm;
    logic [4:0]  hour;
  } guard_beat_t;

  typedef struct packed {
    pump_cmd_e   cmd;
    logic        locked;
    logic [31:0] runtime;
    logic        hold;
  } guard_result_t;

  localparam int unsigned HourMs = 3_600_000;

  // Clock, reset and every block input start at known values.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             req_type_i = 1'b0;
  logic [31:0]      now_ms_i = '0;
  logic             pump_running_i = 1'b0;
  logic             moisture_valid_i = 1'b0;
  logic [9:0]       soil_moisture_i = '0;
  logic [4:0]       hour_of_day_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       pump_command_o;
  logic             pump_locked_o;
  logic [31:0]      window_runtime_ms_o;
  logic             manual_hold_active_o;

  irrigation_pump_guard uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .req_type_i           (req_type_i),
    .now_ms_i             (now_ms_i),
    .pump_running_i       (pump_running_i),
    .moisture_valid_i     (moisture_valid_i),
    .soil_moisture_i      (soil_moisture_i),
    .hour_of_day_i        (hour_of_day_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .pump_command_o       (pump_command_o),
    .pump_locked_o        (pump_locked_o),
    .window_runtime_ms_o  (window_runtime_ms_o),
    .manual_hold_active_o (manual_hold_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration registers, starting from their reset values.
  logic [6:0]         cfg_setpoint = RstSetpoint;
  logic [5:0]         cfg_hyst = RstHysteresis;
  logic [4:0]         cfg_start_hr = RstStartHour;
  logic [4:0]         cfg_end_hr = RstEndHour;
  logic signed [10:0] cfg_offset = RstSpOffset;
  logic [26:0]        cfg_daily_lim = RstDailyLim;
  logic [26:0]        cfg_run_lim = RstRunLim;
  logic [26:0]        cfg_hold_ms = RstHoldMs;

  // Guard state as the block should hold it; all zero after reset.
  logic [31:0] win_start = '0;
  logic [31:0] last_upd = '0;
  logic        last_pump = 1'b0;
  logic [31:0] run_start = '0;
  logic        locked = 1'b0;
  logic [31:0] run_total = '0;
  logic [31:0] hold_until = '0;

  guard_result_t pending_results[$];
  int            fail_count = 0;
  int            results_seen = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Plant model for the random traffic: time, pump and soil evolve plausibly.
  logic [31:0] sim_ms = 32'd1;
  logic        plant_pump = 1'b0;
  int          plant_moist = 500;
  pump_cmd_e   last_cmd = CMD_NONE;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // A hold counts only while its end is nonzero and still ahead (no wrap).
  function automatic logic hold_on(input logic [31:0] now);
    return hold_until != 32'd0 && now < hold_until;
  endfunction

  // Watering hours; the window wraps past midnight when start > end.
  function automatic logic in_hours(input logic [4:0] h);
    if (cfg_start_hr == cfg_end_hr) return 1'b1;
    if (cfg_start_hr < cfg_end_hr) return h >= cfg_start_hr && h < cfg_end_hr;
    return h >= cfg_start_hr || h < cfg_end_hr;
  endfunction

  function automatic void store_cfg(input cfg_reg_e r, input logic [31:0] v);
    case (r)
      REG_SETPOINT:   cfg_setpoint = v[6:0];
      REG_HYSTERESIS: cfg_hyst = v[5:0];
      REG_START_HOUR: cfg_start_hr = v[4:0];
      REG_END_HOUR:   cfg_end_hr = v[4:0];
      REG_SP_OFFSET:  cfg_offset = v[10:0];
      REG_DAILY_LIM:  cfg_daily_lim = v[26:0];
      REG_RUN_LIM:    cfg_run_lim = v[26:0];
      default:        cfg_hold_ms = v[26:0];
    endcase
  endfunction

  // Advance the guard state by one beat and return the result it causes.
  function automatic guard_result_t guard_step(input guard_beat_t b);
    guard_result_t r;
    logic [31:0]   dt;
    logic [31:0]   sum;
    int            sp;
    int            band;
    r.cmd = CMD_NONE;
    if (b.req) begin
      // manual request: arm the hold, touch nothing else
      hold_until = b.now + {5'd0, cfg_hold_ms};
    end else begin
      // open the window on the first step; a window opened at zero reads as closed
      if (win_start == 32'd0) begin
        win_start = b.now;
        last_upd = b.now;
        last_pump = b.pump;
        run_start = b.pump ? b.now : 32'd0;
      end
      dt = b.now - win_start;
      if (dt > WindowSpanMs) begin
        win_start = b.now;
        run_total = '0;
        locked = 1'b0;
      end
      dt = b.now - last_upd;
      last_upd = b.now;
      if (last_pump) begin
        sum = run_total + dt;
        run_total = (sum < run_total) ? 32'hFFFF_FFFF : sum;
      end
      if (b.pump && !last_pump) run_start = b.now;
      last_pump = b.pump;
      if (!locked && run_total > {5'd0, cfg_daily_lim}) locked = 1'b1;
      // a run that started at time zero is never checked
      dt = b.now - run_start;
      if (!locked && b.pump && run_start != 32'd0 && dt > {5'd0, cfg_run_lim})
        locked = 1'b1;

      sp = int'(cfg_setpoint) * 10 + int'(cfg_offset);
      if (sp < int'(SetpMinTenths)) sp = int'(SetpMinTenths);
      if (sp > int'(SetpMaxTenths)) sp = int'(SetpMaxTenths);
      band = int'(cfg_hyst) * 10;
      if (locked) begin
        if (b.pump) r.cmd = CMD_OFF;
      end else if (hold_on(b.now)) begin
        r.cmd = CMD_NONE;
      end else if (!in_hours(b.hour) || !b.valid) begin
        if (b.pump) r.cmd = CMD_OFF;
      end else if (!b.pump && int'(b.sm) < sp - band) begin
        r.cmd = CMD_ON;
      end else if (b.pump && int'(b.sm) > sp + band) begin
        r.cmd = CMD_OFF;
      end
    end
    r.locked = locked;
    r.runtime = run_total;
    r.hold = hold_on(b.now);
    return r;
  endfunction

  // Result side: compare each accepted beat with the oldest expectation and
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin : result_check
    guard_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected result beat: cmd %0d locked %0d runtime %0d",
                                 pump_command_o, pump_locked_o, window_runtime_ms_o));
        end else begin
          want = pending_results.pop_front();
          if (pump_command_o !== want.cmd)
            note_failure($sformatf("beat %0d pump_command: expected %0d, actual %0d",
                                   results_seen, want.cmd, pump_command_o));
          if (pump_locked_o !== want.locked)
            note_failure($sformatf("beat %0d pump_locked: expected %0d, actual %0d",
                                   results_seen, want.locked, pump_locked_o));
          if (window_runtime_ms_o !== want.runtime)
            note_failure($sformatf("beat %0d window_runtime_ms: expected %0d, actual %0d",
                                   results_seen, want.runtime, window_runtime_ms_o));
          if (manual_hold_active_o !== want.hold)
            note_failure($sformatf("beat %0d manual_hold_active: expected %0d, actual %0d",
                                   results_seen, want.hold, manual_hold_active_o));
        end
        results_seen++;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Idle modes: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  task automatic set_idle_mode(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  // Send one beat: drop valid for a random gap, then hold the beat until it is
  // taken. Valid stays high on return so back-to-back beats need no toggle.
  task automatic send_beat(input guard_beat_t b);
    guard_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= b.req;
    now_ms_i         <= b.now;
    pump_running_i   <= b.pump;
    moisture_valid_i <= b.valid;
    soil_moisture_i  <= b.sm;
    hour_of_day_i    <= b.hour;
    do @(posedge clk_i); while (in_stall_o);
    r = guard_step(b);
    pending_results.push_back(r);
    last_cmd = r.cmd;
  endtask

  task automatic step_at(input logic req, input logic [31:0] now, input logic pump,
                         input logic valid, input logic [9:0] sm, input logic [4:0] hour);
    guard_beat_t b;
    b.req = req;
    b.now = now;
    b.pump = pump;
    b.valid = valid;
    b.sm = sm;
    b.hour = hour;
    send_beat(b);
  endtask

  // Hold the sender off until every result is in, then let the pipe settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < 50_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // APB read of one register; compare the implemented bits only.
  task automatic check_reg(input cfg_reg_e r, input logic [31:0] want);
    logic [31:0] mask;
    case (r)
      REG_SETPOINT:               mask = 32'h7F;
      REG_HYSTERESIS:             mask = 32'h3F;
      REG_START_HOUR, REG_END_HOUR: mask = 32'h1F;
      REG_SP_OFFSET:              mask = 32'h7FF;
      default:                    mask = 32'h7FF_FFFF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (want & mask))
      note_failure($sformatf("register %s readback: expected %0h, actual %0h",
                             r.name(), want & mask, prdata & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB write, then read it back; the read's setup phase follows directly.
  task automatic cfg_write(input cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    store_cfg(r, v);
    check_reg(r, v);
  endtask

  task automatic program_cfg(input int sp, input int hy, input int sh, input int eh,
                             input int off, input logic [31:0] daily,
                             input logic [31:0] run, input logic [31:0] hold);
    drain_results();
    cfg_write(REG_SETPOINT, 32'(sp));
    cfg_write(REG_HYSTERESIS, 32'(hy));
    cfg_write(REG_START_HOUR, 32'(sh));
    cfg_write(REG_END_HOUR, 32'(eh));
    cfg_write(REG_SP_OFFSET, 32'(off));
    cfg_write(REG_DAILY_LIM, daily);
    cfg_write(REG_RUN_LIM, run);
    cfg_write(REG_HOLD_MS, hold);
  endtask

  // Next beat of the field traffic: mostly small time steps with the pump
  // obeying the last command, plus long gaps, window-expiring jumps and noise.
  function automatic guard_beat_t field_beat();
    guard_beat_t b;
    int          k;
    k = $urandom_range(99);
    if (k < 70)      sim_ms = sim_ms + $urandom_range(60_000);
    else if (k < 85) sim_ms = sim_ms + $urandom_range(600_000);
    else if (k < 93) sim_ms = sim_ms + $urandom_range(7_200_000);
    else if (k < 97) sim_ms = sim_ms + WindowSpanMs + $urandom_range(3_600_000);
    else if (k < 98) sim_ms = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
    else             sim_ms = $urandom();

    if (last_cmd == CMD_ON) plant_pump = 1'b1;
    else if (last_cmd == CMD_OFF) plant_pump = 1'b0;
    if ($urandom_range(9) == 0) plant_pump = ~plant_pump;

    // soil dries while idle, wets while the pump runs
    plant_moist = plant_moist + int'($urandom_range(60)) - (plant_pump ? 15 : 45);
    if ($urandom_range(19) == 0) plant_moist = int'($urandom_range(1000));
    if (plant_moist < 0) plant_moist = 0;
    if (plant_moist > 1000) plant_moist = 1000;

    b.req = ($urandom_range(99) < 6);
    b.now = sim_ms;
    b.pump = plant_pump;
    b.valid = ($urandom_range(9) != 0);
    b.sm = 10'(plant_moist);
    if ($urandom_range(9) != 0) b.hour = 5'((sim_ms / HourMs) % 24);
    else                        b.hour = 5'($urandom_range(31));
    return b;
  endfunction

  // Random traffic in four stretches: no idling, sender idle, receiver
  // stalling, both; now and then hold off until everything is back.
  task automatic run_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      set_idle_mode((i * 4) / n);
      if ($urandom_range(49) == 0) drain_results();
      send_beat(field_beat());
    end
    drain_results();
  endtask

  task automatic test_register_reset();
    check_reg(REG_SETPOINT, 32'(RstSetpoint));
    check_reg(REG_HYSTERESIS, 32'(RstHysteresis));
    check_reg(REG_START_HOUR, 32'(RstStartHour));
    check_reg(REG_END_HOUR, 32'(RstEndHour));
    check_reg(REG_SP_OFFSET, 32'(RstSpOffset));
    check_reg(REG_DAILY_LIM, 32'(RstDailyLim));
    check_reg(REG_RUN_LIM, 32'(RstRunLim));
    check_reg(REG_HOLD_MS, 32'(RstHoldMs));
  endtask

  // Hand-picked beats under the reset settings (on below 60.0 %, off above 70.0 %,
  // hours 7..19, run limit 5 min, hold 5 min).
  task automatic test_directed_cases();
    set_idle_mode(0);
    step_at(1'b0, 32'd0, 1'b0, 1'b1, 10'd100, 5'd10);       // window opened at zero
    step_at(1'b0, 32'd1000, 1'b0, 1'b1, 10'd100, 5'd10);    // reopens, dry: switch on
    step_at(1'b0, 32'd2000, 1'b1, 1'b1, 10'd650, 5'd10);    // run starts
    step_at(1'b0, 32'd302_001, 1'b1, 1'b1, 10'd650, 5'd10); // run too long: lock
    step_at(1'b0, 32'd303_000, 1'b0, 1'b1, 10'd100, 5'd10); // locked, pump idle
    step_at(1'b0, 32'd86_402_000, 1'b0, 1'b1, 10'd100, 5'd10); // window expiry clears lock
    step_at(1'b1, 32'd86_410_000, 1'b0, 1'b0, 10'd0, 5'd0);    // manual request
    step_at(1'b0, 32'd86_420_000, 1'b1, 1'b1, 10'd1000, 5'd10); // hold yields
    step_at(1'b0, 32'd86_720_000, 1'b1, 1'b1, 10'd1000, 5'd25); // hour out of range
    step_at(1'b0, 32'd86_730_000, 1'b1, 1'b0, 10'd500, 5'd12);  // invalid reading
    step_at(1'b0, 32'd86_740_000, 1'b1, 1'b1, 10'd1000, 5'd19); // run too long: lock, switch off
    step_at(1'b0, 32'd86_750_000, 1'b0, 1'b1, 10'd0, 5'd7);     // locked: no switch on
    step_at(1'b0, 32'd86_760_000, 1'b0, 1'b1, 10'd650, 5'd20);  // end hour, still locked
    step_at(1'b0, 32'd86_770_000, 1'b1, 1'b1, 10'd700, 5'd31);
    // hold whose end wraps to zero is no hold
    step_at(1'b1, 32'hFFFB_6C20, 1'b1, 1'b1, 10'd1000, 5'd31);
    step_at(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'd0, 5'd0);
    // step back in time with the pump on: runtime saturates
    step_at(1'b0, 32'd20_000, 1'b1, 1'b1, 10'd650, 5'd10);
    step_at(1'b0, 32'd10_000, 1'b1, 1'b1, 10'd650, 5'd10);
    // park the window just below the wrap, then start a run at time zero
    step_at(1'b0, 32'hF600_0000, 1'b0, 1'b1, 10'd650, 5'd10);
    step_at(1'b0, 32'hFB26_5C01, 1'b0, 1'b1, 10'd650, 5'd10);
    step_at(1'b0, 32'd0, 1'b1, 1'b1, 10'd300, 5'd10);
    step_at(1'b0, 32'd400_000, 1'b1, 1'b1, 10'd300, 5'd10); // unchecked run
    step_at(1'b0, 32'd500_000, 1'b1, 1'b1, 10'd511, 5'd8);
    step_at(1'b0, 32'd600_000, 1'b0, 1'b1, 10'd512, 5'd16);
    drain_results();
  endtask

  task automatic test_default_settings();
    sim_ms = 32'd5_000_000;
    run_traffic(110);
  endtask

  // Watering window across midnight, tight limits, short hold.
  task automatic test_wrapping_hours();
    program_cfg(40, 2, 22, 6, 35, 32'd200_000, 32'd90_000, 32'd30_000);
    run_traffic(110);
  endtask

  // Lowest settings: always-allowed hours, zero limits, zero hold.
  task automatic test_low_extremes();
    program_cfg(0, 0, 5, 5, -1000, 32'd0, 32'd0, 32'd0);
    run_traffic(100);
  endtask

  task automatic test_high_extremes();
    program_cfg(100, 50, 0, 23, 1000, WindowSpanMs, WindowSpanMs, WindowSpanMs);
    run_traffic(110);
  endtask

  task automatic test_random_settings();
    logic [31:0] lim[3];
    for (int round = 0; round < 4; round++) begin
      for (int j = 0; j < 3; j++)
        lim[j] = ($urandom_range(3) == 0) ? $urandom_range(86_400_000)
                                          : $urandom_range(900_000);
      program_cfg($urandom_range(100), $urandom_range(50), $urandom_range(23),
                  $urandom_range(23), int'($urandom_range(2000)) - 1000,
                  lim[0], lim[1], lim[2]);
      run_traffic(100);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_cases();
    test_default_settings();
    test_wrapping_hours();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();

    drain_results();
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d expected result beats never arrived",
                             pending_results.size()));
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run; a correct run ends far earlier.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ipg_pkg.sv
design/irrigation_pump_guard.sv
verif/tb.sv
